FILE: src/fbcf_pkg.sv
// Package with the shared types and constants of the flash block command framer.
package fbcf_pkg;

  localparam logic [7:0] SYNC0      = 8'h57;
  localparam logic [7:0] SYNC1      = 8'hab;
  localparam logic [7:0] CMD_WRITE  = 8'ha5;
  localparam logic [7:0] CMD_VERIFY = 8'ha6;
  localparam int unsigned GRAIN     = 8;
  localparam int unsigned LEN_EXTRA = 5;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        op;
    logic [15:0] len;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        has_data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HDR,
    B_FIRST,
    B_PAD,
    B_SUM
  } back_state_e;

endpackage

FILE: src/fbcf_if.sv
// Stream interfaces for the request words, the frame words and the key writes.
interface fbcf_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] block_size;
  logic [31:0] address;
  logic [7:0]  data_byte;
  modport source (output valid, operation, block_size, address, data_byte, input ready);
  modport sink (input valid, operation, block_size, address, data_byte, output ready);
endinterface

interface fbcf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic       oversize;
  modport source (output valid, frame_byte, frame_last, oversize, input ready);
  modport sink (input valid, frame_byte, frame_last, oversize, output ready);
endinterface

interface fbcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: src/fbcf_front.sv
// Front end that accepts request words and classifies them into frame commands.
module fbcf_front #(
  parameter int unsigned MAX_BLOCK = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fbcf_req_if.sink             req_i,
  input  fbcf_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output fbcf_pkg::cmd_t       cmd_o
);

  localparam int unsigned LeftW = $clog2(MAX_BLOCK + 1);

  logic             in_frame_q, in_frame_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [16:0]      padded;
  logic [16:0]      len_full;

  assign req_i.ready = !q_status_i.full;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    padded   = (17'(req_i.block_size) + 17'(fbcf_pkg::GRAIN - 1))
             & ~17'(fbcf_pkg::GRAIN - 1);
    len_full = padded + 17'(fbcf_pkg::LEN_EXTRA);
    in_frame_d = in_frame_q;
    left_d     = left_q;
    cmd_o.op       = req_i.operation;
    cmd_o.len      = len_full[15:0];
    cmd_o.addr     = req_i.address;
    cmd_o.data     = req_i.data_byte;
    cmd_o.has_data = 1'b0;
    cmd_o.last     = 1'b0;
    cmd_o.kind     = fbcf_pkg::CMD_DATA;
    if (!in_frame_q) begin
      if (17'(req_i.block_size) > 17'(MAX_BLOCK)) begin
        cmd_o.kind = fbcf_pkg::CMD_REJECT;
      end else begin
        cmd_o.kind     = fbcf_pkg::CMD_START;
        cmd_o.has_data = (req_i.block_size != 16'd0);
        cmd_o.last     = (req_i.block_size == 16'd1);
        if (push_o && req_i.block_size > 16'd1) begin
          in_frame_d = 1'b1;
          left_d     = LeftW'(req_i.block_size - 16'd1);
        end
      end
    end else begin
      cmd_o.last = (left_q == LeftW'(1));
      if (push_o) begin
        left_d = left_q - LeftW'(1);
        if (left_q == LeftW'(1)) begin
          in_frame_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      left_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      left_q     <= left_d;
    end
  end

endmodule

FILE: src/fbcf_queue.sv
// Two-entry command queue between the front end and the back end.
module fbcf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fbcf_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output fbcf_pkg::cmd_t       head_o,
  output fbcf_pkg::q_status_t  status_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  fbcf_pkg::cmd_t     mem_q [Depth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]      cnt_q, cnt_d;

  assign head_o             = mem_q[rd_q];
  assign status_o.full      = (cnt_q == (PtrW + 1)'(Depth));
  assign status_o.not_empty = (cnt_q != '0);

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.not_empty) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW + 1)'(Depth)) else $error("queue count out of range");
`endif

endmodule

FILE: src/fbcf_back.sv
// Back end that emits header, keyed data, padding, checksum and oversize-rejection words.
module fbcf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fbcf_pkg::cmd_t       head_i,
  input  fbcf_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  fbcf_cfg_if.sink             cfg_i,
  fbcf_frame_if.source         frame_o
);

  fbcf_pkg::back_state_e state_q, state_d;
  fbcf_pkg::cmd_t        cur_q, cur_d;
  logic [3:0]            cnt_q, cnt_d;
  logic [2:0]            kpos_q, kpos_d;
  logic [7:0]            sum_q, sum_d;
  logic [63:0]           key_q;
  logic                  ovalid_q, ovalid_d;
  logic [7:0]            obyte_q, obyte_d;
  logic                  olast_q, olast_d;
  logic                  oover_q, oover_d;
  logic                  advance;
  logic                  emit;
  logic [7:0]            key_byte;
  logic [7:0]            hdr_byte;
  logic [7:0]            cmd_byte;

  assign cfg_i.ready        = 1'b1;
  assign frame_o.valid      = ovalid_q;
  assign frame_o.frame_byte = obyte_q;
  assign frame_o.frame_last = olast_q;
  assign frame_o.oversize   = oover_q;
  assign advance            = !ovalid_q || frame_o.ready;
  assign key_byte           = key_q[{kpos_q, 3'b000} +: 8];
  assign cmd_byte           = cur_q.op ? fbcf_pkg::CMD_VERIFY : fbcf_pkg::CMD_WRITE;

  always_comb begin
    case (cnt_q)
      4'd1:    hdr_byte = fbcf_pkg::SYNC1;
      4'd2:    hdr_byte = cmd_byte;
      4'd3:    hdr_byte = cur_q.len[7:0];
      4'd4:    hdr_byte = cur_q.len[15:8];
      4'd5:    hdr_byte = cur_q.addr[7:0];
      4'd6:    hdr_byte = cur_q.addr[15:8];
      4'd7:    hdr_byte = cur_q.addr[23:16];
      4'd8:    hdr_byte = cur_q.addr[31:24];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    kpos_d  = kpos_q;
    sum_d   = sum_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    obyte_d = 8'h00;
    olast_d = 1'b0;
    oover_d = 1'b0;
    if (advance) begin
      case (state_q)
        fbcf_pkg::B_IDLE: begin
          if (q_status_i.not_empty) begin
            pop_o = 1'b1;
            emit  = 1'b1;
            case (head_i.kind)
              fbcf_pkg::CMD_REJECT: begin
                olast_d = 1'b1;
                oover_d = 1'b1;
              end
              fbcf_pkg::CMD_START: begin
                obyte_d = fbcf_pkg::SYNC0;
                cur_d   = head_i;
                cnt_d   = 4'd1;
                sum_d   = 8'h00;
                kpos_d  = 3'd0;
                state_d = fbcf_pkg::B_HDR;
              end
              default: begin
                obyte_d = head_i.data ^ key_byte;
                sum_d   = sum_q + obyte_d;
                kpos_d  = kpos_q + 3'd1;
                if (head_i.last) begin
                  state_d = (kpos_q == 3'd7) ? fbcf_pkg::B_SUM : fbcf_pkg::B_PAD;
                end
              end
            endcase
          end
        end
        fbcf_pkg::B_HDR: begin
          emit    = 1'b1;
          obyte_d = hdr_byte;
          if (cnt_q >= 4'd2) begin
            sum_d = sum_q + obyte_d;
          end
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd9) begin
            state_d = cur_q.has_data ? fbcf_pkg::B_FIRST : fbcf_pkg::B_SUM;
          end
        end
        fbcf_pkg::B_FIRST: begin
          emit    = 1'b1;
          obyte_d = cur_q.data ^ key_byte;
          sum_d   = sum_q + obyte_d;
          kpos_d  = kpos_q + 3'd1;
          if (cur_q.last) begin
            state_d = (kpos_q == 3'd7) ? fbcf_pkg::B_SUM : fbcf_pkg::B_PAD;
          end else begin
            state_d = fbcf_pkg::B_IDLE;
          end
        end
        fbcf_pkg::B_PAD: begin
          emit    = 1'b1;
          obyte_d = key_byte;
          sum_d   = sum_q + obyte_d;
          kpos_d  = kpos_q + 3'd1;
          if (kpos_q == 3'd7) begin
            state_d = fbcf_pkg::B_SUM;
          end
        end
        fbcf_pkg::B_SUM: begin
          emit    = 1'b1;
          obyte_d = sum_q;
          olast_d = 1'b1;
          sum_d   = 8'h00;
          kpos_d  = 3'd0;
          state_d = fbcf_pkg::B_IDLE;
        end
        default: begin
          state_d = fbcf_pkg::B_IDLE;
        end
      endcase
    end
    ovalid_d = emit ? 1'b1 : (frame_o.ready ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      obyte_q <= obyte_d;
      olast_q <= olast_d;
      oover_q <= oover_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fbcf_pkg::B_IDLE;
      cnt_q    <= '0;
      kpos_q   <= '0;
      sum_q    <= '0;
      key_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      kpos_q   <= kpos_d;
      sum_q    <= sum_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid) begin
        key_q <= cfg_i.data;
      end
    end
  end

`ifndef SYNTH
  a_oversize_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && oover_q |-> olast_q) else $error("rejection word without last flag");
  a_pad_unaligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fbcf_pkg::B_PAD |-> kpos_q != 3'd0) else $error("padding when aligned");
  a_sum_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fbcf_pkg::B_SUM |-> kpos_q == 3'd0) else $error("checksum before alignment");
`endif

endmodule

FILE: src/flash_block_command_framer_top.sv
// Top level of the flash block command framer.
//
//  Channel  Direction  Carries
//  req_i    in         operation, block_size, address, data_byte
//  cfg_i    in         session key, 64 bits
//  frame_o  out        frame_byte, frame_last, oversize
//
// One frame word leaves per cycle while the output is taken and work is queued; the
// back end's byte sequencer sets this. A start word gives ten header words, the last
// data word up to 8 more for padding and checksum; the two-entry queue fills meanwhile.
// Reset clears the frame state and the key; the block is ready right after reset.
// A stalled output holds its word while the front end fills the queue.
module flash_block_command_framer_top #(
  parameter int unsigned MAX_BLOCK = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fbcf_req_if.sink     req_i,
  fbcf_cfg_if.sink     cfg_i,
  fbcf_frame_if.source frame_o
);

  fbcf_pkg::cmd_t      push_cmd;
  fbcf_pkg::cmd_t      head;
  fbcf_pkg::q_status_t q_status;
  logic                push;
  logic                pop;

  fbcf_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  fbcf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  fbcf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .cfg_i      (cfg_i),
    .frame_o    (frame_o)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the flash block command framer: directed table, then random frames.
module tb_top;

  localparam int unsigned MAX_BLOCK = 256;
  localparam int unsigned RANDOM_WORDS = 380;

  typedef struct {
    logic [7:0] fbyte;
    logic       last;
    logic       over;
  } frame_word_t;

  typedef struct {
    logic        op;
    logic [15:0] size;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        rejected;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fbcf_req_if   req();
  fbcf_cfg_if   cfg();
  fbcf_frame_if frame();

  flash_block_command_framer_top #(
    .MAX_BLOCK(MAX_BLOCK)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .cfg_i  (cfg),
    .frame_o(frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frame_word_t pending_frame_words[$];

  logic        open_frame;
  logic [8:0]  data_left;
  logic [2:0]  key_idx;
  logic [7:0]  csum;
  logic [63:0] session_key;

  logic        calm;
  logic        cur_rejected;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned frames_built;
  int unsigned rejections;
  int unsigned key_writes;
  int unsigned errors;

  task automatic push_word(input logic [7:0] b, input logic last, input logic over);
    frame_word_t w;
    w.fbyte = b;
    w.last  = last;
    w.over  = over;
    pending_frame_words.push_back(w);
  endtask

  task automatic push_summed(input logic [7:0] b);
    csum = csum + b;
    push_word(b, 1'b0, 1'b0);
  endtask

  task automatic push_data(input logic [7:0] plain);
    logic [7:0] kb;
    kb = session_key[{key_idx, 3'b000} +: 8];
    key_idx = key_idx + 3'd1;
    push_summed(plain ^ kb);
  endtask

  task automatic close_frame();
    while (key_idx != 3'd0) push_data(8'h00);
    push_word(csum, 1'b1, 1'b0);
    open_frame = 1'b0;
    data_left  = '0;
    key_idx    = '0;
    csum       = '0;
  endtask

  task automatic predict_frame_words(input logic op, input logic [15:0] size,
                                     input logic [31:0] addr, input logic [7:0] data);
    int unsigned padded;
    logic [15:0] len;
    if (!open_frame) begin
      if (size > MAX_BLOCK) begin
        rejections++;
        push_word(8'h00, 1'b1, 1'b1);
        return;
      end
      frames_built++;
      padded = ((size + fbcf_pkg::GRAIN - 1) / fbcf_pkg::GRAIN) * fbcf_pkg::GRAIN;
      len = 16'(padded + fbcf_pkg::LEN_EXTRA);
      csum = '0;
      key_idx = '0;
      push_word(fbcf_pkg::SYNC0, 1'b0, 1'b0);
      push_word(fbcf_pkg::SYNC1, 1'b0, 1'b0);
      push_summed(op ? fbcf_pkg::CMD_VERIFY : fbcf_pkg::CMD_WRITE);
      push_summed(len[7:0]);
      push_summed(len[15:8]);
      push_summed(addr[7:0]);
      push_summed(addr[15:8]);
      push_summed(addr[23:16]);
      push_summed(addr[31:24]);
      push_summed(8'h00);
      if (size == 16'd0) begin
        close_frame();
        return;
      end
      open_frame = 1'b1;
      data_left = size[8:0];
    end
    push_data(data);
    data_left = data_left - 9'd1;
    if (data_left == 9'd0) close_frame();
  endtask

  always @(posedge clk) begin
    frame_word_t exp_w;
    if (rst_n) begin
      if (req.valid && req.ready) begin
        if (cur_rejected) begin
          rejections++;
          push_word(8'h00, 1'b1, 1'b1);
        end else begin
          predict_frame_words(req.operation, req.block_size, req.address, req.data_byte);
        end
      end
      if (cfg.valid && cfg.ready) begin
        session_key = cfg.data;
        key_writes++;
      end
      if (frame.valid && frame.ready) begin
        words_checked++;
        if (pending_frame_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame word: byte %h last %b oversize %b", $time,
                   frame.frame_byte, frame.frame_last, frame.oversize);
        end else begin
          exp_w = pending_frame_words.pop_front();
          if (frame.frame_byte !== exp_w.fbyte || frame.frame_last !== exp_w.last ||
              frame.oversize !== exp_w.over) begin
            errors++;
            $display("%0t: frame word mismatch: expected byte %h last %b oversize %b,",
                     $time, exp_w.fbyte, exp_w.last, exp_w.over);
            $display("  actual byte %h last %b oversize %b",
                     frame.frame_byte, frame.frame_last, frame.oversize);
          end
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    frame.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        frame.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      frame.ready = 1'b1;
      do @(posedge clk); while (!(frame.valid && rst_n));
    end
  end

  task automatic send_word(input logic op, input logic [15:0] size, input logic [31:0] addr,
                           input logic [7:0] data, input logic rejected);
    int unsigned gap;
    gap = calm ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.operation  = op;
    req.block_size = size;
    req.address    = addr;
    req.data_byte  = data;
    cur_rejected   = rejected;
    req.valid      = 1'b1;
    do @(posedge clk); while (!req.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (pending_frame_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] k);
    cfg.data  = k;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] size);
    int unsigned n;
    n = (size == 16'd0 || size > MAX_BLOCK) ? 1 : size;
    send_word(1'($urandom_range(0, 1)), size, $urandom, 8'($urandom_range(0, 255)), 1'b0);
    for (int unsigned i = 1; i < n; i++)
      send_word(1'($urandom_range(0, 1)), 16'($urandom), $urandom,
                8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    plan_row_t plan [25];
    logic [63:0] k;
    logic [15:0] size;
    int unsigned r;
    int unsigned p;

    plan = '{
      '{1'b0, 16'd0,     32'h0000_0000, 8'h00, 1'b0},
      '{1'b1, 16'd0,     32'hffff_ffff, 8'hff, 1'b0},
      '{1'b0, 16'd257,   32'h1234_5678, 8'h11, 1'b1},
      '{1'b1, 16'hffff,  32'hffff_ffff, 8'hff, 1'b1},
      '{1'b1, 16'd1,     32'h8000_0001, 8'hff, 1'b0},
      '{1'b0, 16'd3,     32'hffff_ffff, 8'h00, 1'b0},
      '{1'b1, 16'hffff,  32'h0000_0000, 8'h80, 1'b0},
      '{1'b0, 16'h0000,  32'hdead_beef, 8'h7f, 1'b0},
      '{1'b0, 16'd8,     32'h0000_0100, 8'h01, 1'b0},
      '{1'b1, 16'd0,     32'h0000_0000, 8'h02, 1'b0},
      '{1'b0, 16'd300,   32'hffff_ffff, 8'h04, 1'b0},
      '{1'b1, 16'd1,     32'h5555_5555, 8'h08, 1'b0},
      '{1'b0, 16'hffff,  32'haaaa_aaaa, 8'h10, 1'b0},
      '{1'b1, 16'd0,     32'h0000_0001, 8'h20, 1'b0},
      '{1'b0, 16'd8,     32'h0000_0000, 8'h40, 1'b0},
      '{1'b1, 16'd2,     32'hffff_fffe, 8'h80, 1'b0},
      '{1'b1, 16'd9,     32'h00ff_00ff, 8'haa, 1'b0},
      '{1'b0, 16'h8000,  32'h0000_0000, 8'h55, 1'b0},
      '{1'b1, 16'h7fff,  32'hffff_ffff, 8'hfe, 1'b0},
      '{1'b0, 16'd0,     32'h1357_9bdf, 8'h01, 1'b0},
      '{1'b1, 16'd256,   32'h0000_0000, 8'hff, 1'b0},
      '{1'b0, 16'd1,     32'h8000_0000, 8'h00, 1'b0},
      '{1'b1, 16'd257,   32'h0000_0080, 8'hc3, 1'b0},
      '{1'b0, 16'hffff,  32'hffff_0000, 8'h3c, 1'b0},
      '{1'b1, 16'd5,     32'h0000_ffff, 8'h99, 1'b0}
    };

    open_frame = 1'b0;
    data_left = '0;
    key_idx = '0;
    csum = '0;
    session_key = '0;
    calm = 1'b0;
    cur_rejected = 1'b0;
    words_sent = 0;
    words_checked = 0;
    frames_built = 0;
    rejections = 0;
    key_writes = 0;
    errors = 0;
    req.valid = 1'b0;
    req.operation = 1'b0;
    req.block_size = '0;
    req.address = '0;
    req.data_byte = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i])
      send_word(plan[i].op, plan[i].size, plan[i].addr, plan[i].data, plan[i].rejected);
    cur_rejected = 1'b0;

    p = 0;
    while (words_sent < 25 + RANDOM_WORDS) begin
      drain();
      case (p % 5)
        0: k = 64'hffff_ffff_ffff_ffff;
        1: k = 64'h5555_5555_5555_5555;
        2: k = 64'h0;
        3: k = 64'haaaa_aaaa_aaaa_aaaa;
        default: k = {$urandom, $urandom};
      endcase
      write_key(k);
      calm = (p % 4 == 3);
      if (p == 0) send_frame(16'(MAX_BLOCK));
      for (int f = 0; f < 6; f++) begin
        r = $urandom_range(0, 99);
        if (r < 8) size = 16'd0;
        else if (r == 15) size = 16'hffff;
        else if (r < 16) size = 16'($urandom_range(MAX_BLOCK + 1, 65535));
        else if (r < 28) size = 16'($urandom_range(21, 64));
        else size = 16'($urandom_range(1, 20));
        send_frame(size);
      end
      p++;
    end

    drain();
    calm = 1'b0;
    repeat (30) @(posedge clk);
    $display("Sent %0d request words over %0d key settings:", words_sent, key_writes);
    $display("%0d frames built, %0d oversize rejections.", frames_built, rejections);
    $display("Checked %0d frame words, %0d mismatches.", words_checked, errors);
    if (errors == 0 && pending_frame_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd8 * 64'd1_500_000);
    $display("Timed out with %0d frame words outstanding.", pending_frame_words.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
